FILE: rtl/stepper_pulse_generator_with_watchdog_core_macros.svh
// ---------------------------------------------------------------------------
// Stepper pulse generator assertion macros
// Shared concurrent assertion helpers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef STEPPER_PULSE_GENERATOR_WITH_WATCHDOG_CORE_MACROS_SVH
`define STEPPER_PULSE_GENERATOR_WITH_WATCHDOG_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SPG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication
`define SPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SPG_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/spg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper pulse generator package
// Request and result types, operation, status and register codes.
// ---------------------------------------------------------------------------
package spg_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ARM       = 3'd1,
        OP_HEARTBEAT = 3'd2,
        OP_DISARM    = 3'd3,
        OP_STOP_ALL  = 3'd4,
        OP_MOVE      = 3'd5,
        OP_STOP_AXIS = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_ARMED = 3'd1,
        ST_WD_BAD    = 3'd2,
        ST_BAD_ARG   = 3'd3,
        ST_BUSY      = 3'd4,
        ST_REFUSED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAX_STEPS = 2'd0,
        CFG_MIN_SPEED = 2'd1,
        CFG_MAX_SPEED = 2'd2,
        CFG_WD_LIMIT  = 2'd3
    } cfg_idx_t;

    localparam logic [18:0] HALF_MAX = 19'd524287;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  axis;
        logic        direction;
        logic [23:0] step_count;
        logic [19:0] rate_hz;
        logic        permissive;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       armed;
        logic       healthy;
        logic [2:0] moving_mask;
        logic [2:0] step_pins;
        logic [2:0] dir_pins;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_step;
        logic commit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } dp_sts_t;

endpackage

FILE: rtl/spg_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper pulse generator controller
// Sequences one request through execute, then divide and commit for an accepted move, then result.
// ---------------------------------------------------------------------------
module spg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  spg_pkg::dp_sts_t sts,
    output spg_pkg::dp_cmd_t cmd
);
    import spg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMMIT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_div ? S_DIV : S_RESULT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/spg_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper pulse generator datapath
// Watchdog, per-axis step timers, configuration and half-period divider.
// ---------------------------------------------------------------------------
module spg_datapath #(
    parameter int AXES        = 3,
    parameter int TICK_HZ     = 1000000,
    parameter int FIRST_DELAY = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spg_pkg::in_item_t in_item,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    input  spg_pkg::dp_cmd_t  cmd,
    output spg_pkg::dp_sts_t  sts,
    output spg_pkg::out_item_t out_item
);
    import spg_pkg::*;

    localparam int AW  = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int TPM = TICK_HZ / 1000;
    localparam int SW  = $clog2(TPM + 1);
    localparam int DW  = $clog2(TICK_HZ + 1);
    localparam int CW  = $clog2(DW);
    localparam logic [DW-1:0] DIVIDEND = DW'(TICK_HZ);

    // Configuration
    logic [23:0] max_steps_reg;
    logic [18:0] min_speed_reg;
    logic [18:0] max_speed_reg;
    logic [15:0] wd_limit_reg;

    // Control state
    logic          armed_reg, armed_next;
    logic          healthy_reg, healthy_next;
    logic [15:0]   since_reg, since_next;
    logic [SW-1:0] sub_reg, sub_next;
    logic [24:0]   toggles_reg [AXES];
    logic [24:0]   toggles_next [AXES];
    logic [18:0]   cnt_reg [AXES];
    logic [18:0]   cnt_next [AXES];
    logic          step_reg [AXES];
    logic          step_next [AXES];
    logic          dir_reg [AXES];
    logic          dir_next [AXES];

    // Payload
    in_item_t      item_reg;
    logic [18:0]   half_reg [AXES];
    logic [18:0]   half_next [AXES];
    logic [2:0]    status_reg, status_next;
    logic [20:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    out_item_t     out_reg;

    logic [AW-1:0] ax_idx;
    logic          ax_ok;
    logic          args_bad;
    logic          wd_trip;
    logic          tick_trip;
    logic [2:0]    move_status;
    logic [20:0]   divisor;
    logic [21:0]   trial;
    logic [SW:0]   sub_inc;
    logic [15:0]   since_tick;
    logic [18:0]   hp;
    logic          drop_arm;
    logic          halt_all;
    logic          halt_one;
    logic          tick_run;
    logic [2:0]    mov_bits, stp_bits, dir_bits;

    assign ax_idx   = AW'(item_reg.axis);
    assign ax_ok    = int'(item_reg.axis) < AXES;
    assign args_bad = !ax_ok || (item_reg.step_count == 24'd0)
                   || (item_reg.step_count > max_steps_reg)
                   || (item_reg.rate_hz == 20'd0)
                   || (item_reg.rate_hz < {1'b0, min_speed_reg})
                   || (item_reg.rate_hz > {1'b0, max_speed_reg});
    assign wd_trip  = armed_reg && (since_reg > wd_limit_reg);
    assign divisor  = {item_reg.rate_hz, 1'b0};
    assign trial    = {rem_reg, DIVIDEND[dcnt_reg]};

    // Check a move in priority order
    always_comb
    begin
        if (wd_trip || !armed_reg)
            move_status = ST_NOT_ARMED;
        else if (!healthy_reg)
            move_status = ST_WD_BAD;
        else if (args_bad)
            move_status = ST_BAD_ARG;
        else if (toggles_reg[ax_idx] != 25'd0)
            move_status = ST_BUSY;
        else
            move_status = ST_OK;
    end

    assign sts.need_div = (item_reg.operation == OP_MOVE) && (move_status == ST_OK);
    assign sts.div_last = (dcnt_reg == '0);

    // Advance the millisecond counter for a tick
    always_comb
    begin
        sub_inc    = {1'b0, sub_reg} + (SW + 1)'(1);
        since_tick = since_reg;
        if (sub_inc >= (SW + 1)'(TPM))
        begin
            if (since_reg != 16'hFFFF)
                since_tick = since_reg + 16'd1;
        end
        tick_trip = armed_reg && (since_tick > wd_limit_reg);
    end

    // Saturate the divider quotient to a legal half period
    always_comb
    begin
        if (quo_reg == '0)
            hp = 19'd1;
        else if (32'(quo_reg) > 32'(HALF_MAX))
            hp = HALF_MAX;
        else
            hp = 19'(quo_reg);
    end

    // Next state for the executed request
    always_comb
    begin
        armed_next   = armed_reg;
        healthy_next = healthy_reg;
        since_next   = since_reg;
        sub_next     = sub_reg;
        status_next  = status_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        drop_arm     = 1'b0;
        halt_all     = 1'b0;
        halt_one     = 1'b0;
        tick_run     = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            toggles_next[a] = toggles_reg[a];
            cnt_next[a]     = cnt_reg[a];
            step_next[a]    = step_reg[a];
            dir_next[a]     = dir_reg[a];
            half_next[a]    = half_reg[a];
        end

        if (cmd.exec)
        begin
            status_next = ST_OK;
            case (item_reg.operation)
                OP_TICK:
                begin
                    sub_next   = (sub_inc >= (SW + 1)'(TPM)) ? '0 : sub_inc[SW-1:0];
                    since_next = since_tick;
                    drop_arm   = tick_trip;
                    tick_run   = !tick_trip;
                end
                OP_ARM:
                begin
                    if (!item_reg.permissive)
                    begin
                        drop_arm    = 1'b1;
                        status_next = ST_REFUSED;
                    end
                    else
                    begin
                        since_next   = '0;
                        armed_next   = 1'b1;
                        healthy_next = 1'b1;
                    end
                end
                OP_HEARTBEAT:
                begin
                    if (!item_reg.permissive)
                    begin
                        drop_arm    = 1'b1;
                        status_next = ST_REFUSED;
                    end
                    else if (!armed_reg)
                    begin
                        drop_arm    = 1'b1;
                        status_next = ST_NOT_ARMED;
                    end
                    else
                    begin
                        since_next   = '0;
                        healthy_next = 1'b1;
                    end
                end
                OP_DISARM:   drop_arm = 1'b1;
                OP_STOP_ALL: halt_all = 1'b1;
                OP_MOVE:
                begin
                    drop_arm    = wd_trip;
                    status_next = move_status;
                    rem_next    = '0;
                    quo_next    = '0;
                    dcnt_next   = CW'(DW - 1);
                end
                OP_STOP_AXIS:
                begin
                    if (!ax_ok)
                        status_next = ST_BAD_ARG;
                    else
                        halt_one = 1'b1;
                end
                default: status_next = ST_BAD_ARG;
            endcase
        end

        // Drop the arm and stop every axis
        if (drop_arm)
        begin
            armed_next   = 1'b0;
            healthy_next = 1'b0;
            halt_all     = 1'b1;
        end

        for (int a = 0; a < AXES; a++)
        begin
            if (halt_all || (halt_one && (ax_idx == AW'(a))))
            begin
                toggles_next[a] = '0;
                cnt_next[a]     = '0;
                step_next[a]    = 1'b0;
                if (halt_all)
                    dir_next[a] = 1'b0;
            end
            else if (tick_run && (toggles_reg[a] != 25'd0))
            begin
                if (cnt_reg[a] > 19'd1)
                    cnt_next[a] = cnt_reg[a] - 19'd1;
                else if (toggles_reg[a] == 25'd1)
                begin
                    toggles_next[a] = '0;
                    cnt_next[a]     = '0;
                    step_next[a]    = 1'b0;
                end
                else
                begin
                    toggles_next[a] = toggles_reg[a] - 25'd1;
                    cnt_next[a]     = half_reg[a];
                    step_next[a]    = !step_reg[a];
                end
            end
        end

        // One restoring division step per cycle
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = 21'(trial - {1'b0, divisor});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[20:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - CW'(1);
        end

        // Start the accepted move
        if (cmd.commit)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (ax_idx == AW'(a))
                begin
                    dir_next[a]     = item_reg.direction;
                    half_next[a]    = hp;
                    toggles_next[a] = {item_reg.step_count, 1'b0};
                    step_next[a]    = 1'b0;
                    cnt_next[a]     = 19'(FIRST_DELAY);
                end
            end
        end
    end

    // Gather the pin views for the first three axes
    genvar b;
    generate
        for (b = 0; b < 3; b++)
        begin : g_pins
            if (b < AXES)
            begin : g_used
                assign mov_bits[b] = (toggles_reg[b] != 25'd0);
                assign stp_bits[b] = step_reg[b];
                assign dir_bits[b] = dir_reg[b];
            end
            else
            begin : g_unused
                assign mov_bits[b] = 1'b0;
                assign stp_bits[b] = 1'b0;
                assign dir_bits[b] = 1'b0;
            end
        end
    endgenerate

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg <= 24'd16777215;
            min_speed_reg <= 19'd1;
            max_speed_reg <= 19'd20000;
            wd_limit_reg  <= 16'd500;
            armed_reg     <= 1'b0;
            healthy_reg   <= 1'b0;
            since_reg     <= '0;
            sub_reg       <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                toggles_reg[a] <= '0;
                cnt_reg[a]     <= '0;
                step_reg[a]    <= 1'b0;
                dir_reg[a]     <= 1'b0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MAX_STEPS: max_steps_reg <= cfg_data;
                    CFG_MIN_SPEED: min_speed_reg <= cfg_data[18:0];
                    CFG_MAX_SPEED: max_speed_reg <= cfg_data[18:0];
                    CFG_WD_LIMIT:  wd_limit_reg  <= cfg_data[15:0];
                    default:       wd_limit_reg  <= wd_limit_reg;
                endcase
            end
            armed_reg   <= armed_next;
            healthy_reg <= healthy_next;
            since_reg   <= since_next;
            sub_reg     <= sub_next;
            for (int a = 0; a < AXES; a++)
            begin
                toggles_reg[a] <= toggles_next[a];
                cnt_reg[a]     <= cnt_next[a];
                step_reg[a]    <= step_next[a];
                dir_reg[a]     <= dir_next[a];
            end
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= in_item;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        for (int a = 0; a < AXES; a++)
            half_reg[a] <= half_next[a];
        if (cmd.load_out)
        begin
            out_reg.status      <= status_reg;
            out_reg.armed       <= armed_reg;
            out_reg.healthy     <= healthy_reg;
            out_reg.moving_mask <= mov_bits;
            out_reg.step_pins   <= stp_bits;
            out_reg.dir_pins    <= dir_bits;
        end
    end

    assign out_item = out_reg;

endmodule

FILE: rtl/stepper_pulse_generator_with_watchdog_core.sv
`timescale 1ns / 1ps
// Sequence: each request passes execute and result; an accepted move also passes divide and commit
// (one quotient bit per cycle from the half-period divider).
// Flow: one request at a time; a new request is taken only in the idle state.
// The result register frees the input side while a result waits to be taken.
// Reset: asynchronous active low; disarmed, all axes stopped, configuration registers at defaults.
// ---------------------------------------------------------------------------
// Stepper pulse generator with watchdog, top level
// Three-axis step/direction generator with arm and heartbeat watchdog.
// ---------------------------------------------------------------------------
module stepper_pulse_generator_with_watchdog_core #(
    parameter int AXES        = 3,
    parameter int TICK_HZ     = 1000000,
    parameter int FIRST_DELAY = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spg_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output spg_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import spg_pkg::*;

`include "stepper_pulse_generator_with_watchdog_core_macros.svh"

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    spg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    spg_datapath #(
        .AXES        (AXES),
        .TICK_HZ     (TICK_HZ),
        .FIRST_DELAY (FIRST_DELAY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_item)
    );

    `SPG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `SPG_ASSERT_SAME(a_healthy_needs_armed, clk, rst_n, out_valid, out_item.armed || !out_item.healthy)
    `SPG_ASSERT_SAME(a_step_only_moving, clk, rst_n, out_valid, (out_item.step_pins & ~out_item.moving_mask) == 3'b000)

endmodule
